@@ rtl/xed_pkg.sv @@
package xed_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ListLen = 4;
  localparam int unsigned CntW    = 3;

  localparam logic [1:0] KindGt   = 2'd0;
  localparam logic [1:0] KindLt   = 2'd1;
  localparam logic [1:0] KindQuot = 2'd2;
  localparam logic [1:0] KindAmp  = 2'd3;

  localparam logic [ByteW-1:0] ChAmp   = 8'h26;
  localparam logic [ByteW-1:0] ChHash  = 8'h23;
  localparam logic [ByteW-1:0] ChSemi  = 8'h3b;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2b;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;

  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] data;
  } in_beat_t;

  typedef struct packed {
    logic [ListLen-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]               cnt;
    logic                          last;
    logic                          marker;
  } res_list_t;

  // Character at a given position of an entity name, the terminating ';' included.
  function automatic logic [ByteW-1:0] ent_byte(input logic [1:0] kind, input logic [2:0] pos);
    logic [ByteW-1:0] b;
    b = ChSemi;
    case (kind)
      KindGt: begin
        case (pos)
          3'd0:    b = 8'h67;
          3'd1:    b = 8'h74;
          default: b = ChSemi;
        endcase
      end
      KindLt: begin
        case (pos)
          3'd0:    b = 8'h6c;
          3'd1:    b = 8'h74;
          default: b = ChSemi;
        endcase
      end
      KindQuot: begin
        case (pos)
          3'd0:    b = 8'h71;
          3'd1:    b = 8'h75;
          3'd2:    b = 8'h6f;
          3'd3:    b = 8'h74;
          default: b = ChSemi;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    b = 8'h61;
          3'd1:    b = 8'h6d;
          3'd2:    b = 8'h70;
          default: b = ChSemi;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic logic [2:0] ent_len(input logic [1:0] kind);
    logic [2:0] l;
    case (kind)
      KindQuot: l = 3'd5;
      KindAmp:  l = 3'd4;
      default:  l = 3'd3;
    endcase
    return l;
  endfunction

  function automatic logic [ByteW-1:0] ent_out(input logic [1:0] kind);
    logic [ByteW-1:0] b;
    case (kind)
      KindGt:   b = 8'h3e;
      KindLt:   b = 8'h3c;
      KindQuot: b = 8'h22;
      default:  b = ChAmp;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/xed_skid.sv @@
module xed_skid import xed_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  in_beat_t s_beat_i,
  output logic     valid_o,
  output in_beat_t beat_o,
  input  logic     take_i
);

  logic     main_v_q, skid_v_q;
  in_beat_t main_q, skid_q;
  logic     acc;

  assign s_ready_o = !skid_v_q;
  assign acc       = s_valid_i && !skid_v_q;
  assign valid_o   = main_v_q;
  assign beat_o    = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take_i && skid_v_q) begin
      main_v_q <= 1'b1;
      skid_v_q <= 1'b0;
    end else if (take_i) begin
      main_v_q <= acc;
    end else if (acc) begin
      if (!main_v_q) begin
        main_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && skid_v_q) begin
      main_q <= skid_q;
    end else if (acc && (take_i || !main_v_q)) begin
      main_q <= s_beat_i;
    end else if (acc) begin
      skid_q <= s_beat_i;
    end
  end

endmodule

@@ rtl/xed_core.sv @@
module xed_core import xed_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  in_beat_t  beat_i,
  input  logic      load_ok_i,
  output logic      take_o,
  output logic      load_o,
  output res_list_t list_o
);

  localparam logic [2:0] ModePlain = 3'd0;
  localparam logic [2:0] ModeAmp   = 3'd1;
  localparam logic [2:0] ModeName  = 3'd2;
  localparam logic [2:0] ModeNumWs = 3'd3;
  localparam logic [2:0] ModeNumDg = 3'd4;
  localparam logic [2:0] ModeSkip  = 3'd5;

  logic [2:0]       mode_q, mode_d;
  logic [1:0]       kind_q, kind_d;
  logic [2:0]       pos_q, pos_d;
  logic [ByteW-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic             carry_v_q, carry_v_d;
  logic [ByteW-1:0] carry_b_q, carry_b_d;

  logic [ByteW-1:0] c;
  logic             is_ws, is_digit;
  logic [ByteW-1:0] digit;
  logic [1:0]       pre_kind;
  logic [2:0]       pre_len;
  logic             single_v;
  logic [ByteW-1:0] single_b;
  logic [CntW-1:0]  n;
  logic [2:0]       j;

  function automatic logic [ByteW-1:0] num_val(input logic [ByteW-1:0] a, input logic ng);
    return ng ? ByteW'(8'd0 - a) : a;
  endfunction

  assign c        = beat_i.data;
  assign is_ws    = (c == ChSpace) || (c >= ChTab && c <= ChCr);
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign digit    = c - ChZero;
  assign take_o   = valid_i && load_ok_i;

  always_comb begin
    mode_d   = mode_q;
    kind_d   = kind_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    pre_kind = kind_q;
    pre_len  = 3'd0;
    single_v = 1'b0;
    single_b = c;

    case (mode_q)
      ModeAmp: begin
        if (c == 8'h67 || c == 8'h6c || c == 8'h71 || c == 8'h61) begin
          kind_d = (c == 8'h67) ? KindGt : (c == 8'h6c) ? KindLt :
                   (c == 8'h71) ? KindQuot : KindAmp;
          pos_d  = 3'd1;
          mode_d = ModeName;
        end else if (c == ChHash) begin
          acc_d  = '0;
          neg_d  = 1'b0;
          mode_d = ModeNumWs;
        end else if (c == ChAmp) begin
          mode_d = ModeAmp;
        end else begin
          single_v = 1'b1;
          mode_d   = ModePlain;
        end
      end
      ModeName: begin
        if (c == ent_byte(kind_q, pos_q)) begin
          if (pos_q + 3'd1 == ent_len(kind_q)) begin
            single_v = 1'b1;
            single_b = ent_out(kind_q);
            pos_d    = 3'd0;
            mode_d   = ModePlain;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end else begin
          pre_len = pos_q;
          pos_d   = 3'd0;
          if (c == ChAmp) begin
            mode_d = ModeAmp;
          end else begin
            single_v = 1'b1;
            mode_d   = ModePlain;
          end
        end
      end
      ModeNumWs: begin
        if (is_ws) begin
          mode_d = ModeNumWs;
        end else if (c == ChPlus) begin
          mode_d = ModeNumDg;
        end else if (c == ChMinus) begin
          neg_d  = 1'b1;
          mode_d = ModeNumDg;
        end else if (is_digit) begin
          acc_d  = digit;
          mode_d = ModeNumDg;
        end else begin
          single_v = 1'b1;
          single_b = num_val(acc_q, neg_q);
          mode_d   = (c == ChSemi) ? ModePlain : ModeSkip;
        end
      end
      ModeNumDg: begin
        if (is_digit) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + digit;
        end else begin
          single_v = 1'b1;
          single_b = num_val(acc_q, neg_q);
          mode_d   = (c == ChSemi) ? ModePlain : ModeSkip;
        end
      end
      ModeSkip: begin
        if (c == ChSemi) begin
          mode_d = ModePlain;
        end
      end
      default: begin
        if (c == ChAmp) begin
          mode_d = ModeAmp;
        end else begin
          single_v = 1'b1;
          mode_d   = ModePlain;
        end
      end
    endcase

    if (beat_i.last) begin
      if (mode_d == ModeName) begin
        pre_kind = kind_d;
        pre_len  = pos_d;
      end else if (mode_d == ModeNumWs || mode_d == ModeNumDg) begin
        single_v = 1'b1;
        single_b = num_val(acc_d, neg_d);
      end
      mode_d = ModePlain;
      kind_d = KindGt;
      pos_d  = 3'd0;
      acc_d  = '0;
      neg_d  = 1'b0;
    end
  end

  always_comb begin
    n = CntW'(carry_v_q) + pre_len + CntW'(single_v);
    carry_v_d = 1'b0;
    carry_b_d = single_b;
    if (n > CntW'(ListLen) && !beat_i.last) begin
      carry_v_d = 1'b1;
    end

    list_o.last   = beat_i.last;
    list_o.marker = (n == '0);
    list_o.cnt    = (n == '0) ? CntW'(1) : (n > CntW'(ListLen)) ? CntW'(ListLen) : n;
    for (int i = 0; i < ListLen; i++) begin
      j = 3'(i) - 3'(carry_v_q);
      if (carry_v_q && i == 0) begin
        list_o.bytes[i] = carry_b_q;
      end else if (j < pre_len) begin
        list_o.bytes[i] = ent_byte(pre_kind, j);
      end else begin
        list_o.bytes[i] = single_b;
      end
    end
    load_o = take_o && ((n != '0) || beat_i.last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModePlain;
      kind_q    <= KindGt;
      pos_q     <= 3'd0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      carry_v_q <= 1'b0;
      carry_b_q <= '0;
    end else if (take_o) begin
      mode_q    <= mode_d;
      kind_q    <= kind_d;
      pos_q     <= pos_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      carry_v_q <= carry_v_d;
      carry_b_q <= carry_b_d;
    end
  end

endmodule

@@ rtl/xed_emit.sv @@
module xed_emit import xed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  res_list_t        list_i,
  output logic             load_ok_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [ByteW-1:0] byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             string_end_o
);

  logic [ListLen-1:0][ByteW-1:0] bytes_q;
  logic [CntW-1:0]               cnt_q;
  logic                          last_q;
  logic                          marker_q;

  assign valid_o      = (cnt_q != '0);
  assign run_last_o   = (cnt_q == CntW'(1));
  assign string_end_o = last_q && run_last_o;
  assign byte_valid_o = !marker_q;
  assign byte_o       = marker_q ? '0 : bytes_q[0];
  assign load_ok_o    = (cnt_q == '0) || (run_last_o && ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= list_i.cnt;
    end else if (valid_o && ready_i) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= list_i.bytes;
      last_q   <= list_i.last;
      marker_q <= list_i.marker;
    end else if (valid_o && ready_i) begin
      for (int i = 0; i < ListLen - 1; i++) begin
        bytes_q[i] <= bytes_q[i+1];
      end
    end
  end

endmodule

@@ rtl/xml_entity_decoder.sv @@
// Channel  Direction  tdata            tuser                         tlast
// s_axis   in         [7:0] in_byte    none                          in_last
// m_axis   out        [7:0] out_byte   [0] byte_valid, [1] string_end run_last
//
// A beat accepted into the input register is decoded combinationally and loaded
// into the output register once that register can take it; its first result is
// then offered. An item giving n results holds the input until the output register
// reaches its last result; it sends one beat per cycle while m_axis_tready is high.
// Reset clears the parser to plain text and empties both registers.
// The input register takes a beat whenever its skid slot is free, so s_axis_tready
// does not depend on m_axis_tready in the same cycle.
module xml_entity_decoder import xed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] in_byte
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]       m_axis_tuser,   // [0] byte_valid, [1] string_end
  output logic             m_axis_tlast
);

  in_beat_t  s_beat, core_beat;
  logic      core_valid, take, load, load_ok;
  res_list_t list;

  assign s_beat.data = s_axis_tdata;
  assign s_beat.last = s_axis_tlast;

  xed_skid u_skid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_beat_i  (s_beat),
    .valid_o   (core_valid),
    .beat_o    (core_beat),
    .take_i    (take)
  );

  xed_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (core_valid),
    .beat_i    (core_beat),
    .load_ok_i (load_ok),
    .take_o    (take),
    .load_o    (load),
    .list_o    (list)
  );

  xed_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .list_i       (list),
    .load_ok_o    (load_ok),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .byte_o       (m_axis_tdata),
    .byte_valid_o (m_axis_tuser[0]),
    .run_last_o   (m_axis_tlast),
    .string_end_o (m_axis_tuser[1])
  );

endmodule

@@ verif/testbench.sv @@
module testbench;
  import xed_pkg::*;

  typedef enum logic [2:0] {
    PmPlain,
    PmAmp,
    PmName,
    PmNumLead,
    PmNumDigits,
    PmSkip
  } parse_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             run_last;
    logic             string_end;
  } dec_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             fixed;
    dec_beat_t        fixed_beat;
  } text_beat_t;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseBeats  = 110;
  localparam dec_beat_t   NoBeat      = '0;

  localparam int unsigned SendIdle  [4] = '{0, 50, 0, 37};
  localparam int unsigned RecvStall [4] = '{0, 0, 50, 37};

  localparam logic [ByteW-1:0] NameText [4][5] = '{
    '{"g", "t", ";", 8'h00, 8'h00},
    '{"l", "t", ";", 8'h00, 8'h00},
    '{"q", "u", "o", "t", ";"},
    '{"a", "m", "p", ";", 8'h00}
  };
  localparam logic [2:0]       NameLen  [4] = '{3'd3, 3'd3, 3'd5, 3'd4};
  localparam logic [ByteW-1:0] NameChar [4] = '{8'h3e, 8'h3c, 8'h22, ChAmp};

  // Rows with a fixed beat are checked against that beat; the rest use the decoder model.
  localparam text_beat_t DirTable [27] = '{
    '{8'h00,   1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{8'hff,   1'b1, 1'b1, '{8'hff, 1'b1, 1'b1, 1'b1}},
    '{ChAmp,   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{ChAmp,   1'b0, 1'b0, NoBeat},
    '{"g",     1'b0, 1'b0, NoBeat},
    '{"t",     1'b0, 1'b0, NoBeat},
    '{ChSemi,  1'b0, 1'b0, NoBeat},
    '{ChAmp,   1'b0, 1'b0, NoBeat},
    '{"q",     1'b0, 1'b0, NoBeat},
    '{"u",     1'b0, 1'b0, NoBeat},
    '{"o",     1'b0, 1'b0, NoBeat},
    '{"t",     1'b0, 1'b0, NoBeat},
    '{"Z",     1'b0, 1'b0, NoBeat},
    '{"Q",     1'b1, 1'b0, NoBeat},
    '{ChAmp,   1'b0, 1'b0, NoBeat},
    '{ChHash,  1'b0, 1'b0, NoBeat},
    '{ChSpace, 1'b0, 1'b0, NoBeat},
    '{ChMinus, 1'b0, 1'b0, NoBeat},
    '{"3",     1'b0, 1'b0, NoBeat},
    '{"0",     1'b0, 1'b0, NoBeat},
    '{"0",     1'b0, 1'b0, NoBeat},
    '{"x",     1'b0, 1'b0, NoBeat},
    '{"y",     1'b1, 1'b0, NoBeat},
    '{ChAmp,   1'b0, 1'b0, NoBeat},
    '{ChHash,  1'b0, 1'b0, NoBeat},
    '{"1",     1'b0, 1'b0, NoBeat},
    '{"2",     1'b1, 1'b0, NoBeat}
  };

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ByteW-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;

  parse_mode_e      mode   = PmPlain;
  logic [1:0]       kind   = '0;
  logic [2:0]       pos    = '0;
  logic [ByteW-1:0] acc    = '0;
  logic             neg    = 1'b0;
  logic             held_v = 1'b0;
  logic [ByteW-1:0] held   = '0;
  logic [ByteW-1:0] pend [$];
  dec_beat_t        step_out [ListLen];

  text_beat_t  text_q [$];
  dec_beat_t   due [$];
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned sent      = 0;
  int unsigned strings   = 0;
  int unsigned checked   = 0;
  int unsigned errors    = 0;

  xml_entity_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [ByteW-1:0] number_value();
    return neg ? 8'(8'd0 - acc) : acc;
  endfunction

  function automatic void take_plain(input logic [ByteW-1:0] c);
    if (c == ChAmp) begin
      mode = PmAmp;
    end else begin
      pend.push_back(c);
      mode = PmPlain;
    end
  endfunction

  function automatic void flush_name();
    for (int i = 0; i < int'(pos) && i < int'(NameLen[kind]); i++) begin
      pend.push_back(NameText[kind][i]);
    end
  endfunction

  function automatic void end_number(input logic [ByteW-1:0] c);
    pend.push_back(number_value());
    mode = (c == ChSemi) ? PmPlain : PmSkip;
  endfunction

  function automatic int decode_byte(input logic [ByteW-1:0] c, input logic last);
    int n;
    pend.delete();
    if (held_v) begin
      pend.push_back(held);
      held_v = 1'b0;
    end
    case (mode)
      PmAmp: begin
        if (c == "g" || c == "l" || c == "q" || c == "a") begin
          kind = (c == "g") ? KindGt : (c == "l") ? KindLt : (c == "q") ? KindQuot : KindAmp;
          pos  = 3'd1;
          mode = PmName;
        end else if (c == ChHash) begin
          acc  = '0;
          neg  = 1'b0;
          mode = PmNumLead;
        end else begin
          take_plain(c);
        end
      end
      PmName: begin
        if (pos < NameLen[kind] && c == NameText[kind][pos]) begin
          if (int'(pos) + 1 >= int'(NameLen[kind])) begin
            pend.push_back(NameChar[kind]);
            pos  = '0;
            mode = PmPlain;
          end else begin
            pos = pos + 3'd1;
          end
        end else begin
          flush_name();
          pos = '0;
          take_plain(c);
        end
      end
      PmNumLead: begin
        if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
        end else if (c == ChPlus) begin
          mode = PmNumDigits;
        end else if (c == ChMinus) begin
          neg  = 1'b1;
          mode = PmNumDigits;
        end else if (c >= ChZero && c <= ChNine) begin
          acc  = c - ChZero;
          mode = PmNumDigits;
        end else begin
          end_number(c);
        end
      end
      PmNumDigits: begin
        if (c >= ChZero && c <= ChNine) begin
          acc = acc * 8'd10 + (c - ChZero);
        end else begin
          end_number(c);
        end
      end
      PmSkip: begin
        if (c == ChSemi) begin
          mode = PmPlain;
        end
      end
      default: begin
        take_plain(c);
      end
    endcase

    if (last) begin
      if (mode == PmName) begin
        flush_name();
      end else if (mode == PmNumLead || mode == PmNumDigits) begin
        pend.push_back(number_value());
      end
      mode = PmPlain;
      kind = '0;
      pos  = '0;
      acc  = '0;
      neg  = 1'b0;
    end

    n = pend.size();
    if (n > int'(ListLen)) begin
      if (!last) begin
        held   = pend[ListLen];
        held_v = 1'b1;
      end
      n = ListLen;
    end
    if (n == 0 && last) begin
      step_out[0] = '{8'h00, 1'b0, 1'b1, 1'b1};
      n = 1;
    end else begin
      for (int k = 0; k < n; k++) begin
        step_out[k] = '{pend[k], 1'b1, k == n - 1, last && k == n - 1};
      end
    end
    return n;
  endfunction

  function automatic void add_string();
    logic [ByteW-1:0] s [$];
    logic [1:0]       k;
    int               segs;
    int               cut;
    int               base;
    segs = $urandom_range(1, 4);
    for (int i = 0; i < segs; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          s.push_back(8'($urandom));
        end
        3, 4: begin
          k    = 2'($urandom);
          cut  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NameLen[k]) : NameLen[k];
          base = s.size();
          s.push_back(ChAmp);
          for (int j = 0; j < cut; j++) begin
            s.push_back(NameText[k][j]);
          end
          if ($urandom_range(0, 5) == 0) begin
            s[$urandom_range(base + 1, s.size() - 1)] = 8'($urandom);
          end
        end
        5, 6: begin
          s.push_back(ChAmp);
          s.push_back(ChHash);
          repeat ($urandom_range(0, 2)) begin
            s.push_back($urandom_range(0, 1) ? ChSpace : 8'($urandom_range(ChTab, ChCr)));
          end
          case ($urandom_range(0, 2))
            1:       s.push_back(ChPlus);
            2:       s.push_back(ChMinus);
            default: begin
            end
          endcase
          repeat ($urandom_range(0, 4)) begin
            s.push_back(8'(ChZero + $urandom_range(0, 9)));
          end
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              s.push_back(8'($urandom));
            end
          end
          s.push_back(ChSemi);
        end
        7: begin
          s.push_back(ChAmp);
          for (int j = 0; j < 4; j++) begin
            s.push_back(NameText[KindQuot][j]);
          end
          s.push_back(8'($urandom));
        end
        8: begin
          s.push_back(ChAmp);
          s.push_back(8'($urandom));
        end
        default: begin
          s.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end
      endcase
    end
    for (int i = 0; i < s.size(); i++) begin
      text_q.push_back('{s[i], i == s.size() - 1, 1'b0, NoBeat});
    end
  endfunction

  task automatic send_text();
    text_beat_t b;
    int         n;
    while (text_q.size() > 0) begin
      b = text_q.pop_front();
      while ($urandom_range(0, 99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= b.data;
      s_axis_tlast  <= b.last;
      @(posedge clk_i);
      while (!s_axis_tready) begin
        @(posedge clk_i);
      end
      n = decode_byte(b.data, b.last);
      if (b.fixed) begin
        due.push_back(b.fixed_beat);
      end else begin
        for (int k = 0; k < n; k++) begin
          due.push_back(step_out[k]);
        end
      end
      sent++;
      if (b.last) begin
        strings++;
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    dec_beat_t got;
    dec_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: byte %02h valid %0b last %0b end %0b", $time,
                 got.out_byte, got.byte_valid, got.run_last, got.string_end);
      end else begin
        want = due.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                   $time, want.out_byte, want.byte_valid, want.run_last, want.string_end,
                   got.out_byte, got.byte_valid, got.run_last, got.string_end);
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("%0t: timeout with %0d beats outstanding", $time, due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirTable[i]) begin
      text_q.push_back(DirTable[i]);
    end
    send_text();
    while (due.size() > 0) @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = SendIdle[ph];
      stall_pct = RecvStall[ph];
      while (text_q.size() < PhaseBeats) begin
        add_string();
      end
      send_text();
      // The sender holds off until every decoded beat of the phase has arrived.
      while (due.size() > 0) @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d text beats in %0d strings under four handshake patterns.",
             sent, strings);
    $display("%0d decoded beats were checked and %0d errors were found.", checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/xed_pkg.sv
rtl/xed_skid.sv
rtl/xed_core.sv
rtl/xed_emit.sv
rtl/xml_entity_decoder.sv
verif/testbench.sv
